### rtl/core/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg: shared definitions for the Gregorian date difference block
// Widths, the reciprocal used for the divide by 100, status codes and the
// month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package ddd_pkg;

    localparam int YEAR_BITS    = 14;
    localparam int MONTH_BITS   = 4;
    localparam int DAY_BITS     = 5;
    localparam int DAY_NUM_BITS = 22;
    localparam int STATUS_BITS  = 2;

    localparam int YEAR_MAX = 9999;

    // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every y below 2^16.
    localparam int DIV100_SHIFT    = 25;
    localparam int DIV100_MUL      = 335545;
    localparam int DIV100_MUL_BITS = 19;
    localparam int QUOT_BITS       = YEAR_BITS - 6;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_REVERSED = 2'd2
    } status_t;

    // Advance enables for the two date pipeline stages.
    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } ctrl_t;

    // Days in the month, February taken as 28.
    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] month);
        logic [DAY_BITS-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in all earlier months of a common year.
    function automatic logic [8:0] month_before(input logic [MONTH_BITS-1:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ddd_day_number.sv
// ----------------------------------------------------------------------------
// ddd_day_number: two-stage day number pipeline for one date
// Stage one does the constant multiplies (365 * (y - 1) and the reciprocal
// divides by 100); stage two checks the date and sums the day number.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_day_number
(
    input  wire                             clk,
    input  wire ddd_pkg::ctrl_t             ctrl,
    input  wire [ddd_pkg::YEAR_BITS-1:0]    year,
    input  wire [ddd_pkg::MONTH_BITS-1:0]   month,
    input  wire [ddd_pkg::DAY_BITS-1:0]     day,
    output logic [ddd_pkg::DAY_NUM_BITS-1:0] day_num,
    output logic                            date_ok
);

    localparam int YB        = ddd_pkg::YEAR_BITS;
    localparam int QB        = ddd_pkg::QUOT_BITS;
    localparam int PROD_BITS = YB + ddd_pkg::DIV100_MUL_BITS;
    localparam int P365_BITS = YB + 9;
    localparam int SUM_BITS  = YB + 10;

    // Stage one.
    logic [YB-1:0]                   year_reg, p_reg;
    logic [ddd_pkg::MONTH_BITS-1:0]  month_reg;
    logic [ddd_pkg::DAY_BITS-1:0]    day_reg;
    logic [P365_BITS-1:0]            p365_reg;
    logic [QB-1:0]                   qy_reg, qp_reg;
    logic                            range_ok_reg;

    logic [YB-1:0]         p_next;
    logic [PROD_BITS-1:0]  prod_y, prod_p;
    logic                  range_ok_next;

    assign p_next = year - YB'(1);
    assign prod_y = PROD_BITS'(year) * PROD_BITS'(ddd_pkg::DIV100_MUL);
    assign prod_p = PROD_BITS'(p_next) * PROD_BITS'(ddd_pkg::DIV100_MUL);
    assign range_ok_next = (year != '0)
                        && (16'(year) <= 16'(ddd_pkg::YEAR_MAX))
                        && (month != '0) && (month <= 4'd12)
                        && (day != '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_en)
        begin
            year_reg     <= year;
            p_reg        <= p_next;
            month_reg    <= month;
            day_reg      <= day;
            p365_reg     <= P365_BITS'(p_next) * P365_BITS'(365);
            qy_reg       <= prod_y[ddd_pkg::DIV100_SHIFT +: QB];
            qp_reg       <= prod_p[ddd_pkg::DIV100_SHIFT +: QB];
            range_ok_reg <= range_ok_next;
        end
    end

    // Stage two. A year divisible by 100 is exactly one whose quotient by 100
    // differs from that of the year before it.
    logic                              century, leap;
    logic [ddd_pkg::DAY_BITS-1:0]      len;
    logic [SUM_BITS-1:0]               sum;
    logic                              ok_next;
    logic [ddd_pkg::DAY_NUM_BITS-1:0]  day_num_reg;
    logic                              date_ok_reg;

    always_comb
    begin
        century = (qy_reg != qp_reg);
        leap    = (year_reg[1:0] == 2'b00) && (!century || (qy_reg[1:0] == 2'b00));
        len     = ddd_pkg::month_len(month_reg)
                + ddd_pkg::DAY_BITS'((month_reg == 4'd2) && leap);
        ok_next = range_ok_reg && (day_reg <= len);
        sum     = SUM_BITS'(p365_reg)
                + SUM_BITS'(p_reg >> 2)
                - SUM_BITS'(qp_reg)
                + SUM_BITS'(qp_reg >> 2)
                + SUM_BITS'(ddd_pkg::month_before(month_reg))
                + SUM_BITS'((month_reg > 4'd2) && leap)
                + SUM_BITS'(day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_en)
        begin
            day_num_reg <= sum[ddd_pkg::DAY_NUM_BITS-1:0];
            date_ok_reg <= ok_next;
        end
    end

    assign day_num = day_num_reg;
    assign date_ok = date_ok_reg;

endmodule

`default_nettype wire

### rtl/core/date_difference_days.sv
// ----------------------------------------------------------------------------
// date_difference_days: days between two Gregorian dates
// Three-stage pipeline: constant multiplies, date check and day number,
// then the difference and status.
// ----------------------------------------------------------------------------
// Each item carries a start date and an end date; the result is the end day
// number minus the start day number, with status 1 for an invalid date (year
// outside 1..9999, bad month or day) and status 2 for an end before the start,
// the difference reading zero in both cases. One item is accepted every cycle
// while in_stall is low, and its result passes through the three register stages
// (multiply, day number sum, subtract). A stall on the output holds the last
// stage while the earlier stages keep filling their empty slots.
`default_nettype none

module date_difference_days
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire [ddd_pkg::YEAR_BITS-1:0]          start_year,
    input  wire [ddd_pkg::MONTH_BITS-1:0]         start_month,
    input  wire [ddd_pkg::DAY_BITS-1:0]           start_day,
    input  wire [ddd_pkg::YEAR_BITS-1:0]          end_year,
    input  wire [ddd_pkg::MONTH_BITS-1:0]         end_month,
    input  wire [ddd_pkg::DAY_BITS-1:0]           end_day,
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic [ddd_pkg::DAY_NUM_BITS-1:0]      day_difference,
    output logic [ddd_pkg::STATUS_BITS-1:0]       status
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    ddd_pkg::ctrl_t ctrl;

    // A stage moves when it is empty or the stage after it moves.
    assign adv3 = !v3_reg || !out_stall;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_stall   = !adv1;
    assign ctrl.s1_en = adv1;
    assign ctrl.s2_en = adv2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    logic [ddd_pkg::DAY_NUM_BITS-1:0] start_num, end_num;
    logic                             start_ok, end_ok;

    ddd_day_number u_start
    (
        .clk     (clk),
        .ctrl    (ctrl),
        .year    (start_year),
        .month   (start_month),
        .day     (start_day),
        .day_num (start_num),
        .date_ok (start_ok)
    );

    ddd_day_number u_end
    (
        .clk     (clk),
        .ctrl    (ctrl),
        .year    (end_year),
        .month   (end_month),
        .day     (end_day),
        .day_num (end_num),
        .date_ok (end_ok)
    );

    logic [ddd_pkg::DAY_NUM_BITS-1:0] diff_reg, diff_next;
    ddd_pkg::status_t                 status_reg, status_next;

    always_comb
    begin
        diff_next   = '0;
        status_next = ddd_pkg::STATUS_OK;
        if (!start_ok || !end_ok)
        begin
            status_next = ddd_pkg::STATUS_INVALID;
        end
        else if (end_num < start_num)
        begin
            status_next = ddd_pkg::STATUS_REVERSED;
        end
        else
        begin
            diff_next = end_num - start_num;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            diff_reg   <= diff_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = v3_reg;
    assign day_difference = diff_reg;
    assign status         = status_reg;

    // An accepted item always occupies the first stage on the next cycle.
    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted item did not enter the first stage");

    // A nonzero status always comes with a zero difference.
    a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ddd_pkg::STATUS_OK)) |-> (day_difference == '0))
        else $error("nonzero difference reported with an error status");

    // A full pipeline under output stall must push back on the input.
    a_full_stalls : assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && out_stall) |-> in_stall)
        else $error("input not stalled while every stage is held");

endmodule

`default_nettype wire
